FILE: src/seep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seep_pkg: shared types and constants of the serial EEPROM
// Block geometry, action and phase codes, and the store request bundle.
// ----------------------------------------------------------------------------
package seep_pkg;

   localparam int ADDR_BITS  = 6;
   localparam int BLOCK_BITS = 64;
   localparam int NUM_BLOCKS = 1 << ADDR_BITS;
   localparam int CNT_W      = $clog2(BLOCK_BITS);
   localparam int BUSY_W     = 18;
   localparam int TICK_W     = 12;

   localparam logic [BUSY_W-1:0] BUSY_RESET = BUSY_W'(500);

   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_WRITE   = 2'd1,
      ACT_READ    = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_START  = 3'd1,
      PH_RADDR  = 3'd2,
      PH_WADDR  = 3'd3,
      PH_WDATA  = 3'd4,
      PH_WTERM  = 3'd5,
      PH_RDUMMY = 3'd6,
      PH_RDATA  = 3'd7
   } phase_type;

   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      logic [ADDR_BITS-1:0]  addr;
      logic [BLOCK_BITS-1:0] wdata;
   } store_req_type;

endpackage

FILE: src/seep_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seep_store: block store
// One-port block memory with per-block valid bits; unwritten blocks read as
// all ones. Read data is registered.
// ----------------------------------------------------------------------------
module seep_store
   import seep_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  store_req_type         req,
   output logic [BLOCK_BITS-1:0] rd_data
);

   logic [BLOCK_BITS-1:0] mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] valid_ff;
   logic [BLOCK_BITS-1:0] rd_word_ff;
   logic                  rd_hit_ff;

   // mark written blocks, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.addr] <= 1'b1;
      end
   end

   // write and read the array
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.rd_en) begin
         rd_word_ff <= mem[req.addr];
         rd_hit_ff  <= valid_ff[req.addr];
      end
   end

   // unwritten block reads as erased
   assign rd_data = rd_hit_ff ? rd_word_ff : '1;

endmodule

FILE: src/seep_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seep_ctrl: serial protocol sequencer
// Decodes host bits, shifts address and data one bit per beat, drives the
// block store and keeps the busy countdown.
// ----------------------------------------------------------------------------
module seep_ctrl
   import seep_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  action_type            action,
   input  logic                  data_bit,
   input  logic [TICK_W-1:0]     tick_cycles,
   input  logic [BUSY_W-1:0]     busy_cycles,
   input  logic [BLOCK_BITS-1:0] rd_data,
   output store_req_type         store_req,
   output logic                  loading,
   output logic                  rsp_valid,
   output logic                  rsp_bit
);

   phase_type             phase_ff, phase_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [BLOCK_BITS-1:0] shift_ff, shift_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [BUSY_W-1:0]     busy_ff, busy_in;
   logic                  load_ff, load_in;
   logic [BUSY_W-1:0]     tick_ext;

   assign tick_ext = {{(BUSY_W-TICK_W){1'b0}}, tick_cycles};
   assign loading  = load_ff;

   // hold state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         shift_ff <= '0;
         addr_ff  <= '0;
         busy_ff  <= '0;
         load_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         addr_ff  <= addr_in;
         busy_ff  <= busy_in;
         load_ff  <= load_in;
      end
   end

   // next state and beat outputs
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      shift_in  = shift_ff;
      addr_in   = addr_ff;
      busy_in   = busy_ff;
      load_in   = 1'b0;
      store_req = '0;
      rsp_valid = 1'b0;
      rsp_bit   = 1'b1;

      // capture the block fetched for a read
      if (load_ff) begin
         shift_in = rd_data;
      end

      if (take) begin
         case (action)
            ACT_TICK: begin
               busy_in = (busy_ff > tick_ext) ? busy_ff - tick_ext : '0;
            end
            ACT_WRITE: begin
               if (busy_ff == '0) begin
                  case (phase_ff)
                     PH_IDLE: begin
                        if (data_bit) phase_in = PH_START;
                     end
                     PH_START: begin
                        phase_in = data_bit ? PH_RADDR : PH_WADDR;
                        count_in = '0;
                        addr_in  = '0;
                     end
                     PH_RADDR, PH_WADDR: begin
                        addr_in  = {addr_ff[ADDR_BITS-2:0], data_bit};
                        count_in = count_ff + CNT_W'(1);
                        if (count_ff == CNT_W'(ADDR_BITS - 1)) begin
                           count_in = '0;
                           if (phase_ff == PH_RADDR) begin
                              store_req.rd_en = 1'b1;
                              store_req.addr  = addr_in;
                              load_in         = 1'b1;
                              phase_in        = PH_RDUMMY;
                           end else begin
                              shift_in = '0;
                              phase_in = PH_WDATA;
                           end
                        end
                     end
                     PH_WDATA: begin
                        shift_in = {shift_ff[BLOCK_BITS-2:0], data_bit};
                        count_in = count_ff + CNT_W'(1);
                        if (count_ff == CNT_W'(BLOCK_BITS - 1)) begin
                           count_in        = '0;
                           store_req.wr_en = 1'b1;
                           store_req.addr  = addr_ff;
                           store_req.wdata = shift_in;
                           phase_in        = PH_WTERM;
                        end
                     end
                     PH_WTERM: begin
                        phase_in = PH_IDLE;
                        busy_in  = busy_cycles;
                     end
                     default: begin
                        // start bit restarts a read out
                        if (data_bit) phase_in = PH_START;
                     end
                  endcase
               end
            end
            ACT_READ: begin
               rsp_valid = 1'b1;
               if (busy_ff != '0) begin
                  rsp_bit = 1'b0;
               end else if (phase_ff == PH_RDUMMY) begin
                  rsp_bit  = 1'b0;
                  count_in = '0;
                  phase_in = PH_RDATA;
               end else if (phase_ff == PH_RDATA) begin
                  rsp_bit  = shift_ff[BLOCK_BITS-1];
                  shift_in = {shift_ff[BLOCK_BITS-2:0], 1'b0};
                  count_in = count_ff + CNT_W'(1);
                  if (count_ff == CNT_W'(BLOCK_BITS - 1)) begin
                     count_in = '0;
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
               count_in = '0;
            end
         endcase
      end
   end

endmodule

FILE: src/serial_eeprom_bit_protocol.sv
`timescale 1ns / 1ps
// Response: a read beat's result is registered onto rsp in the cycle after acceptance.
// Throughput: one beat per cycle while the result slot is free or being taken;
// after a read address completes, beats wait while the data shift register fills.
// Reset: synchronous; phase idle, countdown zero, busy time 500, all blocks
// read as all ones through per-block valid bits cleared at once.
// ----------------------------------------------------------------------------
// serial_eeprom_bit_protocol: bit-serial EEPROM top level
// Stream handshakes, busy time register and result register around the
// protocol sequencer and block store.
// ----------------------------------------------------------------------------
module serial_eeprom_bit_protocol
   import seep_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // [0] data_bit, [12:1] tick_cycles, zero fill
   input  logic [1:0]        req_tuser,   // [1:0] action
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [0] read_bit, zero fill
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [BUSY_W-1:0] csr_wdata
);

   logic [BUSY_W-1:0]     busy_cycles_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_bit_ff;
   logic                  take;
   logic                  loading;
   logic                  beat_valid;
   logic                  beat_bit;
   store_req_type         store_req;
   logic [BLOCK_BITS-1:0] rd_data;

   // accept a beat when no fetch is pending and the result slot frees up
   assign req_tready = !loading && (!rsp_valid_ff || rsp_tready);
   assign take       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // hold busy time register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_cycles_ff <= BUSY_RESET;
      end else if (csr_valid) begin
         busy_cycles_ff <= csr_wdata;
      end
   end

   // hold result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (beat_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_valid) begin
         rsp_bit_ff <= beat_bit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_bit_ff};

   seep_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .action      (action_type'(req_tuser)),
      .data_bit    (req_tdata[0]),
      .tick_cycles (req_tdata[TICK_W:1]),
      .busy_cycles (busy_cycles_ff),
      .rd_data     (rd_data),
      .store_req   (store_req),
      .loading     (loading),
      .rsp_valid   (beat_valid),
      .rsp_bit     (beat_bit)
   );

   seep_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (store_req),
      .rd_data (rd_data)
   );

endmodule
